/* rtl/core/itp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg: shared types and codes for the infix to postfix converter
// token kinds, result kinds, stack entry codes, operator precedence
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int unsigned DEFAULT_STACK_DEPTH = 16;

    // input token kinds
    localparam logic [2:0] CMD_OPERAND  = 3'd0;
    localparam logic [2:0] CMD_LPAREN   = 3'd1;
    localparam logic [2:0] CMD_RPAREN   = 3'd2;
    localparam logic [2:0] CMD_OPERATOR = 3'd3;
    localparam logic [2:0] CMD_ASSIGN   = 3'd4;
    localparam logic [2:0] CMD_END      = 3'd5;

    // operator codes
    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_MINUS = 3'd1;
    localparam logic [2:0] OP_TIMES = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_POW   = 3'd4;
    localparam logic [2:0] OP_MOD   = 3'd5;

    // stack entries above the operator codes
    localparam logic [2:0] ENT_LPAREN = 3'd6;
    localparam logic [2:0] ENT_ASSIGN = 3'd7;

    // result kinds
    localparam logic [2:0] KIND_OPERAND  = 3'd0;
    localparam logic [2:0] KIND_OPERATOR = 3'd1;
    localparam logic [2:0] KIND_LPAREN   = 3'd2;
    localparam logic [2:0] KIND_ASSIGN   = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    localparam logic [1:0] PREC_ADD = 2'd1;
    localparam logic [1:0] PREC_MUL = 2'd2;
    localparam logic [1:0] PREC_POW = 2'd3;

    // stack control from the sequencer
    typedef struct packed {
        logic       rd;
        logic       push;
        logic       pop;
        logic [2:0] wdata;
    } stk_ctl_t;

    // decision on the current top of stack
    typedef struct packed {
        logic pop;
        logic discard;
    } pop_dec_t;

    function automatic logic [1:0] prec_of(input logic [2:0] code);
        logic [1:0] p;
        p = PREC_ADD;
        if (code == OP_POW) begin
            p = PREC_POW;
        end else if (code == OP_TIMES || code == OP_DIV || code == OP_MOD) begin
            p = PREC_MUL;
        end
        return p;
    endfunction

    function automatic logic [2:0] entry_kind(input logic [2:0] ent);
        logic [2:0] k;
        k = KIND_OPERATOR;
        if (ent == ENT_LPAREN) begin
            k = KIND_LPAREN;
        end else if (ent == ENT_ASSIGN) begin
            k = KIND_ASSIGN;
        end
        return k;
    endfunction

    function automatic logic [2:0] entry_op(input logic [2:0] ent);
        logic [2:0] o;
        o = ent;
        if (ent == ENT_LPAREN || ent == ENT_ASSIGN) begin
            o = 3'd0;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/itp_stack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itp_stack: bounded operator stack
// single port memory with registered top read and an entry count
// ----------------------------------------------------------------------------
module itp_stack #(
    parameter int unsigned STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire itp_pkg::stk_ctl_t ctl,
    output logic [2:0]            rd_data,
    output logic                  empty,
    output logic                  full
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);

    logic [2:0]    mem [STACK_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [2:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(STACK_DEPTH));
    assign rd_addr = AW'(count_reg - CW'(1));
    assign rd_data = rd_data_reg;

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push && !full) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.pop && !empty) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && !full) begin
            mem[count_reg[AW-1:0]] <= ctl.wdata;
        end
        if (ctl.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/itp_pop_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pop_unit: shared top of stack decision
// precedence compare used once per examined stack entry
// ----------------------------------------------------------------------------
module itp_pop_unit (
    input  wire logic [2:0]        cmd,
    input  wire logic [2:0]        op,
    input  wire logic [2:0]        top,
    output itp_pkg::pop_dec_t      dec
);

    logic top_is_op;

    assign top_is_op = (top != itp_pkg::ENT_LPAREN) && (top != itp_pkg::ENT_ASSIGN);

    always_comb
    begin
        dec = '0;
        case (cmd)
            itp_pkg::CMD_RPAREN:
            begin
                // matching paren is dropped, anything else leaves
                if (top == itp_pkg::ENT_LPAREN) begin
                    dec.discard = 1'b1;
                end else begin
                    dec.pop = 1'b1;
                end
            end
            itp_pkg::CMD_OPERATOR:
            begin
                // left associative: pop on greater or equal precedence
                dec.pop = top_is_op && (itp_pkg::prec_of(top) >= itp_pkg::prec_of(op));
            end
            itp_pkg::CMD_END:
            begin
                dec.pop = 1'b1;
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/infix_to_postfix_converter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit: shunting-yard token converter
// takes classified infix tokens and delivers postfix tokens in order
// ----------------------------------------------------------------------------
// One item in is one classified token; it yields zero or more result items,
// the last of which carries last. An operand goes through the held slot and
// the flush state; a left paren or '=' is pushed straight from idle. Every
// stack entry that is examined takes a memory read, then a precedence
// decision in the shared pop unit, and an item that yields results closes in
// the flush or end state, which hands over its final result. An operator or
// right paren pops entries until the stack runs empty or it stops at an entry
// that stays or at the matching paren; an end token pops every entry before
// its end marker. A receiver that holds off stalls popping and the hand-over.
// The block takes no new item until the current one is finished, but a
// result still waiting on the output does not hold the input back. A push to
// a full stack is dropped and reported on the next end marker's overflow.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit #(
    parameter int unsigned STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // token input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [2:0]  op_code,
    input  wire logic [15:0] operand_ref,
    // postfix output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       out_kind,
    output logic [2:0]       out_op,
    output logic [15:0]      out_ref,
    output logic             overflow,
    output logic             last
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_ENDM  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic [2:0]         op_reg, op_next;
    logic               ovf_reg, ovf_next;

    // held result: kept back one step so that last can be set on it
    logic               held_valid_reg, held_valid_next;
    logic [2:0]         held_kind_reg, held_kind_next;
    logic [2:0]         held_op_reg, held_op_next;
    logic [15:0]        held_ref_reg, held_ref_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_kind_reg, out_kind_next;
    logic [2:0]         out_op_reg, out_op_next;
    logic [15:0]        out_ref_reg, out_ref_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_last_reg, out_last_next;

    itp_pkg::stk_ctl_t  stk_ctl;
    logic [2:0]         stk_top;
    logic               stk_empty;
    logic               stk_full;
    itp_pkg::pop_dec_t  dec;
    logic               slot_free;

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (stk_ctl),
        .rd_data (stk_top),
        .empty   (stk_empty),
        .full    (stk_full)
    );

    itp_pop_unit u_pop (
        .cmd (cmd_reg),
        .op  (op_reg),
        .top (stk_top),
        .dec (dec)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_op    = out_op_reg;
    assign out_ref   = out_ref_reg;
    assign overflow  = out_ovf_reg;
    assign last      = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        op_next         = op_reg;
        ovf_next        = ovf_reg;
        held_valid_next = held_valid_reg;
        held_kind_next  = held_kind_reg;
        held_op_next    = held_op_reg;
        held_ref_next   = held_ref_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_op_next     = out_op_reg;
        out_ref_next    = out_ref_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        stk_ctl         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd_next = cmd;
                    op_next  = op_code;
                    case (cmd)
                        itp_pkg::CMD_OPERAND:
                        begin
                            held_valid_next = 1'b1;
                            held_kind_next  = itp_pkg::KIND_OPERAND;
                            held_op_next    = 3'd0;
                            held_ref_next   = operand_ref;
                            state_next      = ST_FLUSH;
                        end
                        itp_pkg::CMD_LPAREN:
                        begin
                            stk_ctl.push  = 1'b1;
                            stk_ctl.wdata = itp_pkg::ENT_LPAREN;
                            if (stk_full) begin
                                ovf_next = 1'b1;
                            end
                        end
                        itp_pkg::CMD_ASSIGN:
                        begin
                            stk_ctl.push  = 1'b1;
                            stk_ctl.wdata = itp_pkg::ENT_ASSIGN;
                            if (stk_full) begin
                                ovf_next = 1'b1;
                            end
                        end
                        itp_pkg::CMD_RPAREN,
                        itp_pkg::CMD_END:
                        begin
                            state_next = ST_READ;
                        end
                        itp_pkg::CMD_OPERATOR:
                        begin
                            // unknown operator codes are ignored
                            if (op_code <= itp_pkg::OP_MOD) begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                if (stk_empty) begin
                    case (cmd_reg)
                        itp_pkg::CMD_OPERATOR:
                        begin
                            stk_ctl.push  = 1'b1;
                            stk_ctl.wdata = op_reg;
                            if (stk_full) begin
                                ovf_next = 1'b1;
                            end
                            state_next = ST_FLUSH;
                        end
                        itp_pkg::CMD_END:
                        begin
                            state_next = ST_ENDM;
                        end
                        default:
                        begin
                            state_next = ST_FLUSH;
                        end
                    endcase
                end else begin
                    stk_ctl.rd = 1'b1;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if (dec.pop) begin
                    // pop the top into the held slot once the old one can leave
                    if (!held_valid_reg || slot_free) begin
                        if (held_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_kind_next  = held_kind_reg;
                            out_op_next    = held_op_reg;
                            out_ref_next   = held_ref_reg;
                            out_ovf_next   = 1'b0;
                            out_last_next  = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_kind_next  = itp_pkg::entry_kind(stk_top);
                        held_op_next    = itp_pkg::entry_op(stk_top);
                        held_ref_next   = 16'd0;
                        stk_ctl.pop     = 1'b1;
                        state_next      = ST_READ;
                    end
                end else if (dec.discard) begin
                    // matching left paren found
                    stk_ctl.pop = 1'b1;
                    state_next  = ST_FLUSH;
                end else begin
                    // popping stopped, operator goes on the stack
                    stk_ctl.push  = 1'b1;
                    stk_ctl.wdata = op_reg;
                    if (stk_full) begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                if (!held_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = held_kind_reg;
                    out_op_next     = held_op_reg;
                    out_ref_next    = held_ref_reg;
                    out_ovf_next    = 1'b0;
                    out_last_next   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_ENDM:
            begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    if (held_valid_reg) begin
                        out_kind_next   = held_kind_reg;
                        out_op_next     = held_op_reg;
                        out_ref_next    = held_ref_reg;
                        out_ovf_next    = 1'b0;
                        out_last_next   = 1'b0;
                        held_valid_next = 1'b0;
                    end else begin
                        // end marker carries the sticky drop flag
                        out_kind_next = itp_pkg::KIND_END;
                        out_op_next   = 3'd0;
                        out_ref_next  = 16'd0;
                        out_ovf_next  = ovf_reg;
                        out_last_next = 1'b1;
                        ovf_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            ovf_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ovf_reg        <= ovf_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        op_reg        <= op_next;
        held_kind_reg <= held_kind_next;
        held_op_reg   <= held_op_next;
        held_ref_reg  <= held_ref_next;
        out_kind_reg  <= out_kind_next;
        out_op_reg    <= out_op_next;
        out_ref_reg   <= out_ref_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    // nothing may be left over from the previous item when a new one enters
    a_ready_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !held_valid_reg)
        else $error("held result present while ready");

    // overflow only ever rides on the end marker
    a_ovf_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (out_kind == itp_pkg::KIND_END))
        else $error("overflow on a non-end result");

    // end marker always closes its item
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == itp_pkg::KIND_END) |-> last)
        else $error("end marker without last");

    // a dropped push must be remembered
    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (stk_ctl.push && stk_full) |=> ovf_reg)
        else $error("dropped push not flagged");

endmodule
`default_nettype wire

/* dv/infix_to_postfix_converter_unit_test.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_test: token-level check of the converter
// drives classified infix tokens through valid/ready with random gaps on
// both sides, predicts the postfix stream with a shunting-yard model of its
// own and compares every result item field by field, in order
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit_test;

    localparam int unsigned DEPTH          = itp_pkg::DEFAULT_STACK_DEPTH;
    localparam int          WATCHDOG_LIMIT = 2000; // cycles without any handshake
    localparam int          HOLD_OFF       = 160;  // long receiver stall
    localparam int          SETTLE         = 48;   // latency margin at the end
    localparam int          RANDOM_ITEMS   = 150;  // counted items before the quiet tail
    localparam int          TOTAL_ITEMS    = 185;

    // one postfix result as seen on the output
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  op;
        logic [15:0] handle;
        logic        ovf;
        logic        last_flag;
    } postfix_t;

    // one row of the directed table
    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  op;
        logic [15:0] handle;
        bit          typed;
        postfix_t    want;
    } token_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [2:0]  op_code;
    logic [15:0] operand_ref;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  out_kind;
    logic [2:0]  out_op;
    logic [15:0] out_ref;
    logic        overflow;
    logic        last;

    // sideband travelling with the item: typed-in expectation from the table
    bit          row_typed;
    postfix_t    row_want;

    // predictor state
    logic [2:0]  op_stack_m [DEPTH];
    int unsigned stack_fill;
    bit          dropped_push;

    // expected postfix results, oldest first
    postfix_t    postfix_due [$];
    postfix_t    scratch_q [$];
    token_row_t  directed_rows [$];

    // run control and bookkeeping
    bit send_gaps;
    bit recv_gaps;
    bit hold_req;
    int items_sent;
    int ignored_sent;
    int results_checked;
    int end_markers;
    int overflow_markers;
    int mismatches;
    int stall_cycles;

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH (DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .op_code     (op_code),
        .operand_ref (operand_ref),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_kind    (out_kind),
        .out_op      (out_op),
        .out_ref     (out_ref),
        .overflow    (overflow),
        .last        (last)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // shunting-yard predictor
    // ------------------------------------------------------------------------

    // binding strength: power over the multiplicative group over plus/minus
    function automatic logic [1:0] binding(input logic [2:0] code);
        logic [1:0] b;
        case (code)
            itp_pkg::OP_POW:
                b = itp_pkg::PREC_POW;
            itp_pkg::OP_TIMES, itp_pkg::OP_DIV, itp_pkg::OP_MOD:
                b = itp_pkg::PREC_MUL;
            default:
                b = itp_pkg::PREC_ADD;
        endcase
        return b;
    endfunction

    function automatic postfix_t make_result(input logic [2:0] kind, input logic [2:0] op,
                                             input logic [15:0] handle, input logic ovf);
        postfix_t r;
        r.kind      = kind;
        r.op        = op;
        r.handle    = handle;
        r.ovf       = ovf;
        r.last_flag = 1'b0;
        return r;
    endfunction

    // what a popped stack entry turns into on the output
    function automatic postfix_t popped_result(input logic [2:0] ent);
        postfix_t r;
        if (ent == itp_pkg::ENT_LPAREN) begin
            r = make_result(itp_pkg::KIND_LPAREN, 3'd0, 16'd0, 1'b0);
        end else if (ent == itp_pkg::ENT_ASSIGN) begin
            r = make_result(itp_pkg::KIND_ASSIGN, 3'd0, 16'd0, 1'b0);
        end else begin
            r = make_result(itp_pkg::KIND_OPERATOR, ent, 16'd0, 1'b0);
        end
        return r;
    endfunction

    // a push onto a full stack is lost and remembered until the next end
    function automatic void stack_push(input logic [2:0] ent);
        if (stack_fill >= DEPTH) begin
            dropped_push = 1'b1;
        end else begin
            op_stack_m[stack_fill] = ent;
            stack_fill++;
        end
    endfunction

    task automatic shunt_token(input logic [2:0] c, input logic [2:0] o,
                               input logic [15:0] h, ref postfix_t res[$]);
        int          first;
        bit          stop;
        logic [2:0]  top;
        postfix_t    tail;
        first = res.size();
        case (c)
            itp_pkg::CMD_OPERAND:
                res.push_back(make_result(itp_pkg::KIND_OPERAND, 3'd0, h, 1'b0));
            itp_pkg::CMD_LPAREN:
                stack_push(itp_pkg::ENT_LPAREN);
            itp_pkg::CMD_RPAREN: begin
                // unwind to the nearest '(' and drop it; no '(' empties the stack
                while (stack_fill > 0 &&
                       op_stack_m[stack_fill - 1] != itp_pkg::ENT_LPAREN) begin
                    stack_fill--;
                    res.push_back(popped_result(op_stack_m[stack_fill]));
                end
                if (stack_fill > 0) begin
                    stack_fill--;
                end
            end
            itp_pkg::CMD_OPERATOR: begin
                if (o <= itp_pkg::OP_MOD) begin
                    // left-assoc: pop while the top binds at least as tightly
                    stop = 1'b0;
                    while (stack_fill > 0 && !stop) begin
                        top = op_stack_m[stack_fill - 1];
                        if (top > itp_pkg::OP_MOD || binding(top) < binding(o)) begin
                            stop = 1'b1;
                        end else begin
                            stack_fill--;
                            res.push_back(popped_result(top));
                        end
                    end
                    stack_push(o);
                end
            end
            itp_pkg::CMD_ASSIGN:
                stack_push(itp_pkg::ENT_ASSIGN);
            itp_pkg::CMD_END: begin
                while (stack_fill > 0) begin
                    stack_fill--;
                    res.push_back(popped_result(op_stack_m[stack_fill]));
                end
                res.push_back(make_result(itp_pkg::KIND_END, 3'd0, 16'd0, dropped_push));
                dropped_push = 1'b0;
            end
            default: ;
        endcase
        if (res.size() > first) begin
            tail = res.pop_back();
            tail.last_flag = 1'b1;
            res.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------------
    // checking and watchdog, all on values sampled before the edge
    // ------------------------------------------------------------------------

    task automatic note_mismatch(input string what, input postfix_t want, input postfix_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s) at %0t: expected kind %0d op %0d ref %h ovf %b last %b,",
                     what, $realtime, want.kind, want.op, want.handle, want.ovf,
                     want.last_flag);
            $display("    got kind %0d op %0d ref %h ovf %b last %b",
                     got.kind, got.op, got.handle, got.ovf, got.last_flag);
        end
    endtask

    always @(posedge clk) begin
        postfix_t got;
        postfix_t want;
        bit       moved;
        moved = 1'b0;
        if (rst_n) begin
            // output side: oldest expectation first
            if (out_valid && out_ready) begin
                moved = 1'b1;
                got.kind      = out_kind;
                got.op        = out_op;
                got.handle    = out_ref;
                got.ovf       = overflow;
                got.last_flag = last;
                if (postfix_due.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = postfix_due.pop_front();
                    if (got !== want) begin
                        note_mismatch("wrong field", want, got);
                    end
                end
                results_checked++;
                if (got.kind == itp_pkg::KIND_END) begin
                    end_markers++;
                    if (got.ovf) begin
                        overflow_markers++;
                    end
                end
            end
            // input side: predict what this token will produce
            if (in_valid && in_ready) begin
                moved = 1'b1;
                scratch_q.delete();
                shunt_token(cmd, op_code, operand_ref, scratch_q);
                if (row_typed) begin
                    postfix_due.push_back(row_want);
                end else begin
                    foreach (scratch_q[i]) begin
                        postfix_due.push_back(scratch_q[i]);
                    end
                end
            end
            // watchdog on handshakes
            if (moved) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                         stall_cycles, postfix_due.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            if (hold_req) begin
                // long stall so the block backs up and refuses input
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                hold_req = 1'b0;
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offer one item, optionally after an idle burst, and wait for acceptance
    task automatic send_token(input logic [2:0] c, input logic [2:0] o, input logic [15:0] h,
                              input bit typed, input postfix_t want);
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        op_code     <= o;
        operand_ref <= h;
        row_typed   <= typed;
        row_want    <= want;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        if (c > itp_pkg::CMD_END || (c == itp_pkg::CMD_OPERATOR && o > itp_pkg::OP_MOD)) begin
            ignored_sent++;
        end else begin
            items_sent++;
        end
    endtask

    // don't-care fields carry random bits so every input bit toggles
    task automatic send_plain(input logic [2:0] c, input logic [2:0] o);
        send_token(c, o, 16'($urandom_range(0, 65535)), 1'b0, '0);
    endtask

    // look at the queue once the checker has seen the edge, resume on a rising edge
    task automatic wait_drained();
        @(negedge clk);
        while (postfix_due.size() != 0) begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    function automatic void plan_row(input logic [2:0] c, input logic [2:0] o,
                                     input logic [15:0] h, input bit typed,
                                     input logic [2:0] kind);
        token_row_t r;
        r.cmd    = c;
        r.op     = o;
        r.handle = h;
        r.typed  = typed;
        r.want   = make_result(kind, 3'd0, (kind == itp_pkg::KIND_OPERAND) ? h : 16'd0, 1'b0);
        r.want.last_flag = 1'b1;
        directed_rows.push_back(r);
    endfunction

    // well-formed infix expression with random content and bounded nesting
    task automatic gen_expr(input int depth);
        int terms;
        int t;
        terms = $urandom_range(1, 4);
        for (t = 0; t < terms; t++) begin
            if (t > 0) begin
                send_plain(itp_pkg::CMD_OPERATOR, 3'($urandom_range(0, 5)));
            end
            if (depth < 3 && $urandom_range(0, 3) == 0) begin
                send_plain(itp_pkg::CMD_LPAREN, 3'($urandom_range(0, 7)));
                gen_expr(depth + 1);
                send_plain(itp_pkg::CMD_RPAREN, 3'($urandom_range(0, 7)));
            end else begin
                send_plain(itp_pkg::CMD_OPERAND, 3'($urandom_range(0, 7)));
            end
        end
    endtask

    // one random statement: mostly well formed, some broken, some noise
    task automatic gen_statement();
        int pick;
        int n;
        int k;
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
            // optional "x =" prefix, then an expression, then end
            if ($urandom_range(0, 1) == 1) begin
                send_plain(itp_pkg::CMD_OPERAND, 3'($urandom_range(0, 7)));
                send_plain(itp_pkg::CMD_ASSIGN, 3'($urandom_range(0, 7)));
            end
            gen_expr(0);
            send_plain(itp_pkg::CMD_END, 3'($urandom_range(0, 7)));
        end else if (pick == 7) begin
            // broken sequence of legal kinds, end only sometimes
            n = $urandom_range(2, 8);
            for (k = 0; k < n; k++) begin
                send_plain(3'($urandom_range(0, 5)), 3'($urandom_range(0, 5)));
            end
            if ($urandom_range(0, 1) == 1) begin
                send_plain(itp_pkg::CMD_END, 3'($urandom_range(0, 7)));
            end
        end else if (pick == 8) begin
            // raw noise, unknown kinds and operator codes included
            n = $urandom_range(2, 5);
            for (k = 0; k < n; k++) begin
                send_plain(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end
        end else begin
            // deep nesting, often past the stack depth
            n = $urandom_range(8, 20);
            for (k = 0; k < n; k++) begin
                send_plain(itp_pkg::CMD_LPAREN, 3'($urandom_range(0, 7)));
            end
            send_plain(itp_pkg::CMD_OPERAND, 3'($urandom_range(0, 7)));
            n = $urandom_range(0, n);
            for (k = 0; k < n; k++) begin
                send_plain(itp_pkg::CMD_RPAREN, 3'($urandom_range(0, 7)));
            end
            send_plain(itp_pkg::CMD_END, 3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        int k;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        cmd         <= itp_pkg::CMD_OPERAND;
        op_code     <= itp_pkg::OP_PLUS;
        operand_ref <= 16'd0;
        row_typed   <= 1'b0;
        row_want    <= '0;
        send_gaps   = 1'b1;
        recv_gaps   = 1'b1;
        hold_req    = 1'b0;
        stack_fill  = 0;
        dropped_push = 1'b0;
        stall_cycles = 0;
        foreach (op_stack_m[i]) begin
            op_stack_m[i] = 3'd0;
        end

        // directed table: extremes, every operator, every special case
        // end on empty stack
        plan_row(itp_pkg::CMD_END,      3'd7,              16'h0000, 1'b1, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERAND,  3'd7,              16'h0000, 1'b1,
                 itp_pkg::KIND_OPERAND);
        plan_row(itp_pkg::CMD_OPERAND,  3'd0,              16'hFFFF, 1'b1,
                 itp_pkg::KIND_OPERAND);
        plan_row(itp_pkg::CMD_ASSIGN,   3'd0,              16'hFFFF, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_LPAREN,   3'd7,              16'h5A5A, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERAND,  3'd0,              16'h1234, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERATOR, itp_pkg::OP_PLUS,  16'hA5A5, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERAND,  3'd0,              16'h8001, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERATOR, itp_pkg::OP_TIMES, 16'h0000, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERAND,  3'd0,              16'h7FFE, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERATOR, itp_pkg::OP_POW,   16'h0000, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERAND,  3'd0,              16'h0F0F, 1'b0, itp_pkg::KIND_END);
        // equal binding pops
        plan_row(itp_pkg::CMD_OPERATOR, itp_pkg::OP_POW,   16'h0000, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERAND,  3'd0,              16'hF0F0, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERATOR, itp_pkg::OP_DIV,   16'h0000, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERATOR, itp_pkg::OP_MOD,   16'h0000, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERAND,  3'd0,              16'h0001, 1'b0, itp_pkg::KIND_END);
        // stops at the paren
        plan_row(itp_pkg::CMD_OPERATOR, itp_pkg::OP_MINUS, 16'h0000, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_RPAREN,   3'd0,              16'h0000, 1'b0, itp_pkg::KIND_END);
        // unknown operator
        plan_row(itp_pkg::CMD_OPERATOR, 3'd6,              16'h0000, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_OPERATOR, 3'd7,              16'h0000, 1'b0, itp_pkg::KIND_END);
        // unknown kinds
        plan_row(3'd6,                  itp_pkg::OP_PLUS,  16'h0000, 1'b0, itp_pkg::KIND_END);
        plan_row(3'd7,                  itp_pkg::OP_PLUS,  16'h0000, 1'b0, itp_pkg::KIND_END);
        // no '(' left: empties
        plan_row(itp_pkg::CMD_RPAREN,   3'd0,              16'h0000, 1'b0, itp_pkg::KIND_END);
        // stray '('
        plan_row(itp_pkg::CMD_LPAREN,   3'd0,              16'h0000, 1'b0, itp_pkg::KIND_END);
        plan_row(itp_pkg::CMD_END,      3'd0,              16'h0000, 1'b0, itp_pkg::KIND_END);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_token(directed_rows[i].cmd, directed_rows[i].op, directed_rows[i].handle,
                       directed_rows[i].typed, directed_rows[i].want);
        end
        in_valid <= 1'b0;
        wait_drained();

        // full stack: every push kind dropped, then an end with the most results
        for (k = 0; k < DEPTH; k++) begin
            send_plain(itp_pkg::CMD_LPAREN, 3'($urandom_range(0, 7)));
        end
        send_plain(itp_pkg::CMD_ASSIGN, 3'($urandom_range(0, 7)));
        send_plain(itp_pkg::CMD_OPERATOR, itp_pkg::OP_PLUS);
        send_plain(itp_pkg::CMD_LPAREN, 3'($urandom_range(0, 7)));
        send_plain(itp_pkg::CMD_END, 3'($urandom_range(0, 7)));
        send_plain(itp_pkg::CMD_END, 3'($urandom_range(0, 7)));    // flag must have cleared
        in_valid <= 1'b0;
        wait_drained();

        // back-pressure: receiver holds off while a long statement keeps coming
        send_gaps = 1'b0;
        hold_req  = 1'b1;
        send_plain(itp_pkg::CMD_OPERAND, 3'($urandom_range(0, 7)));
        for (k = 0; k < 20; k++) begin
            send_plain(itp_pkg::CMD_OPERATOR, 3'($urandom_range(0, 5)));
            send_plain(itp_pkg::CMD_OPERAND, 3'($urandom_range(0, 7)));
        end
        send_plain(itp_pkg::CMD_END, 3'($urandom_range(0, 7)));
        in_valid <= 1'b0;
        wait_drained();

        // random statements, gaps switched on and off in stretches
        while (items_sent < RANDOM_ITEMS) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            gen_statement();
        end

        // quiet tail at full rate on both sides
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        do begin
            gen_statement();
        end while (items_sent < TOTAL_ITEMS);
        in_valid <= 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("run covered %0d tokens plus %0d ignored, %0d postfix results checked",
                 items_sent, ignored_sent, results_checked);
        $display("%0d end markers seen, %0d of them with overflow, %0d mismatches",
                 end_markers, overflow_markers, mismatches);
        if (postfix_due.size() != 0) begin
            $display("%0d expected results never arrived", postfix_due.size());
        end
        if (mismatches == 0 && postfix_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* infix_to_postfix_converter_unit.f */
rtl/core/itp_pkg.sv
rtl/core/itp_stack.sv
rtl/core/itp_pop_unit.sv
rtl/core/infix_to_postfix_converter_unit.sv
dv/infix_to_postfix_converter_unit_test.sv
